// ===== sv/assert_macros.svh =====
// assertion macros shared by the voice allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

// ===== sv/mva_pkg.sv =====
// shared types and constants of the voice allocator
package mva_pkg;

  localparam int VOICE_COUNT = 16;
  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VOICE_IDX_W = 6;
  localparam int STAMP_W = 32;
  localparam int NOTE_W = 7;
  localparam int CHAN_W = 4;
  localparam int VEL_W = 7;
  localparam int INSTR_W = 8;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;

  // midi message types
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON = 4'h9;

  // configuration register indexes
  localparam logic CFG_STEAL = 1'b0;
  localparam logic CFG_IGN_CHAN = 1'b1;

  localparam logic [CHAN_W-1:0] IGN_CHAN_RESET = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // one voice as seen by the scan unit
  typedef struct packed {
    logic               en;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [STAMP_W-1:0] stamp;
  } slot_rd_t;

  // verdict of the scan unit for the voice under test
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] best_idx;
  } scan_res_t;

  // write request into the voice table
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic               on;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [STAMP_W-1:0] stamp;
  } slot_wr_t;

endpackage

// ===== sv/mva_slot_table.sv =====
// voice table: enable flags, note, channel and activation stamp per voice
module mva_slot_table
  import mva_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  slot_wr_t               wr,
  input  logic [IDX_W-1:0]       rd_addr,
  output slot_rd_t               rd,
  output logic [VOICE_COUNT-1:0] en_vec
);

  logic [VOICE_COUNT-1:0] en_r;
  logic [NOTE_W-1:0]      note_r  [VOICE_COUNT];
  logic [CHAN_W-1:0]      chan_r  [VOICE_COUNT];
  logic [STAMP_W-1:0]     stamp_r [VOICE_COUNT];

  // enable flags clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (wr.we) begin
      en_r[wr.addr] <= wr.on;
    end
  end

  // payload, stamp only moves on note-on
  always_ff @(posedge clk) begin
    if (wr.we) begin
      note_r[wr.addr] <= wr.note;
      chan_r[wr.addr] <= wr.chan;
      if (wr.on) begin
        stamp_r[wr.addr] <= wr.stamp;
      end
    end
  end

  // single read port for the scan
  always_comb begin
    rd.en    = en_r[rd_addr];
    rd.note  = note_r[rd_addr];
    rd.chan  = chan_r[rd_addr];
    rd.stamp = stamp_r[rd_addr];
  end

  assign en_vec = en_r;

endmodule

// ===== sv/mva_scan_unit.sv =====
// shared compare unit: free/match test and oldest-stamp tracking, one voice a cycle
module mva_scan_unit
  import mva_pkg::*;
(
  input  logic              clk,
  input  logic              step,
  input  logic [IDX_W-1:0]  idx,
  input  logic              mode_on,
  input  logic [NOTE_W-1:0] note,
  input  logic [CHAN_W-1:0] chan,
  input  slot_rd_t          slot,
  output scan_res_t         res
);

  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic               take;

  // strict less keeps the lowest index among equal stamps
  assign take = (idx == '0) || (slot.stamp < best_stamp_r);

  // note-on wants a free voice, note-off wants an enabled match
  always_comb begin
    if (mode_on) begin
      res.hit = !slot.en;
    end else begin
      res.hit = slot.en && (slot.note == note) && (slot.chan == chan);
    end
    res.best_idx = take ? idx : best_idx_r;
  end

  always_ff @(posedge clk) begin
    if (step && take) begin
      best_idx_r   <= idx;
      best_stamp_r <= slot.stamp;
    end
  end

endmodule

// ===== sv/midi_voice_allocator.sv =====
// midi voice allocator top level: sequencer, config registers and result register
//
//   channel   dir   tdata / fields                           handshake
//   in_       in    status, note, velocity, instrument       tvalid/tready
//   out_      out   index, note, channel, velocity, instr    tvalid/tready, tuser = on
//   cfg_      in    steal_when_full, ignored_channel         cfg_we only
//
// a note request is accepted in ST_IDLE, scanned through the shared compare unit in
// ST_SCAN (one voice per cycle) and, on a hit or a steal, written in ST_WRITE. ignored
// or foreign messages leave the sequencer idle. reset is synchronous, active low, and
// clears all voice enables, the activation counter and steal; ignored channel goes to 9.
// the write cycle waits while a previous result is still held in the output register.
`include "assert_macros.svh"
module midi_voice_allocator
  import mva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // status_byte[7:0], note_byte[14:8], velocity_byte[21:15], instrument_select[29:22]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voice_index[5:0], voice_note[12:6], voice_channel[16:13], voice_velocity[23:17],
  // voice_instrument[31:24]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // voice_on[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CHAN_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   target_r, target_nxt;
  logic [STAMP_W-1:0] cnt_r, cnt_nxt;
  logic               steal_r;
  logic [CHAN_W-1:0]  ign_chan_r;

  logic               on_r;
  logic [NOTE_W-1:0]  note_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [VEL_W-1:0]   vel_r;
  logic [INSTR_W-1:0] instr_r;

  logic                  out_valid_r;
  logic                  out_on_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [7:0]         in_status;
  logic [NOTE_W-1:0]  in_note;
  logic [VEL_W-1:0]   in_vel;
  logic [INSTR_W-1:0] in_instr;
  logic [3:0]         in_type;
  logic [CHAN_W-1:0]  in_chan;
  logic               in_take;
  logic               in_note_msg;

  logic                   wr_go;
  logic                   scan_step;
  slot_rd_t               slot;
  slot_wr_t               wr;
  scan_res_t              scan;
  logic [VOICE_COUNT-1:0] en_vec;
  logic                   last_idx;

  // input unpack
  assign in_status = in_tdata[7:0];
  assign in_note   = in_tdata[14:8];
  assign in_vel    = in_tdata[21:15];
  assign in_instr  = in_tdata[29:22];
  assign in_type   = in_status[7:4];
  assign in_chan   = in_status[3:0];

  assign in_tready   = (state_r == ST_IDLE);
  assign in_take     = in_tvalid && in_tready;
  assign in_note_msg = ((in_type == MSG_NOTE_OFF) || (in_type == MSG_NOTE_ON))
                       && (in_chan != ign_chan_r);
  assign last_idx    = (idx_r == IDX_W'(VOICE_COUNT - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_r    <= 1'b0;
      ign_chan_r <= IGN_CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEAL:    steal_r    <= cfg_wdata[0];
        CFG_IGN_CHAN: ign_chan_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (in_take) begin
      on_r    <= (in_type == MSG_NOTE_ON) && (in_vel != '0);
      note_r  <= in_note;
      chan_r  <= in_chan;
      vel_r   <= in_vel;
      instr_r <= in_instr;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    target_nxt = target_r;
    cnt_nxt    = cnt_r;
    wr_go      = 1'b0;
    scan_step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take && in_note_msg) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        if (scan.hit) begin
          target_nxt = idx_r;
          state_nxt  = ST_WRITE;
        end else if (last_idx) begin
          if (on_r && steal_r) begin
            target_nxt = scan.best_idx;
            state_nxt  = ST_WRITE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          wr_go     = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    target_r <= target_nxt;
  end

  // voice table write
  always_comb begin
    wr.we    = wr_go;
    wr.addr  = target_r;
    wr.on    = on_r;
    wr.note  = note_r;
    wr.chan  = chan_r;
    wr.stamp = cnt_nxt;
  end

  mva_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (idx_r),
    .rd      (slot),
    .en_vec  (en_vec)
  );

  mva_scan_unit u_scan (
    .clk     (clk),
    .step    (scan_step),
    .idx     (idx_r),
    .mode_on (on_r),
    .note    (note_r),
    .chan    (chan_r),
    .slot    (slot),
    .res     (scan)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_on_r   <= on_r;
      out_data_r <= {instr_r, vel_r, chan_r, note_r, VOICE_IDX_W'(target_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_on_r;

  // checks
  `ASSERT_NEXT(a_enable_follows_write, wr_go, en_vec[$past(target_r)] == $past(on_r), "voice enable does not match written request")
  `ASSERT_NEXT(a_counter_step, wr_go, cnt_r == $past(cnt_r) + 1'b1, "activation counter did not advance by one")
  `ASSERT_ALWAYS(a_no_overwrite, !(wr_go && out_valid_r && !out_tready), "result overwritten while held")
  `ASSERT_ALWAYS(a_scan_range, (state_r != ST_SCAN) || (idx_r <= IDX_W'(VOICE_COUNT - 1)), "scan index out of range")

endmodule
